### rtl/rci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rci_pkg
// Shared constants and types of the row-column block interleaver.
// ----------------------------------------------------------------------------
package rci_pkg;

  // Size of the cell store by default.
  localparam int MAX_CELLS_DEFAULT = 64;

  // Width of the dimension registers and of the numeric scan descriptor fields.
  localparam int CFG_W = 7;

  // Configuration register indexes.
  localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT    = 2'd1;
  localparam logic [1:0] REG_DIRECTION    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 7'd1;
  localparam logic [CFG_W-1:0] ROW_COUNT_RESET    = 7'd1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } rci_state_t;

  // Describes one readout pass over the cell store.
  typedef struct packed {
    logic             in_order;   // arrival order, used for a partial block
    logic [CFG_W-1:0] stride;     // address step inside the inner loop
    logic [CFG_W-1:0] inner_len;  // trip count of the inner loop
    logic [CFG_W-1:0] length;     // total number of cells read
  } rci_scan_t;

endpackage
`default_nettype wire

### rtl/rci_cell_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rci_cell_ram
// Byte store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rci_cell_ram #(
  parameter int MAX_CELLS = rci_pkg::MAX_CELLS_DEFAULT,
  parameter int ADDR_W    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [MAX_CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/rci_addr_gen.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rci_addr_gen
// Read address sequencer: walks the cell store in arrival order or in the
// transposed order of a row-column matrix, one address per step.
// ----------------------------------------------------------------------------
module rci_addr_gen #(
  parameter int MAX_CELLS = rci_pkg::MAX_CELLS_DEFAULT,
  parameter int ADDR_W    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
  input  wire logic              clk,
  input  wire logic              start,
  input  wire logic              step,
  input  wire rci_pkg::rci_scan_t scan,
  output logic      [ADDR_W-1:0] addr,
  output logic                   last
);

  localparam int CW    = rci_pkg::CFG_W;
  localparam int SUM_W = CW + 1;

  rci_pkg::rci_scan_t scan_q;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  inner;
  logic [ADDR_W-1:0]  outer;
  logic [ADDR_W-1:0]  count;

  logic [ADDR_W-1:0]  idx_next;
  logic [ADDR_W-1:0]  inner_next;
  logic [ADDR_W-1:0]  outer_next;
  logic [SUM_W-1:0]   stride_sum;
  logic               inner_end;

  assign stride_sum = SUM_W'(idx) + SUM_W'(scan_q.stride);
  assign inner_end  = (CW'(inner) == (scan_q.inner_len - CW'(1)));

  always_comb begin
    idx_next   = idx;
    inner_next = inner;
    outer_next = outer;
    if (scan_q.in_order) begin
      idx_next = idx + ADDR_W'(1);
    end else if (inner_end) begin
      // The inner loop wraps: the next pass starts at the next outer index.
      outer_next = outer + ADDR_W'(1);
      inner_next = '0;
      idx_next   = outer + ADDR_W'(1);
    end else begin
      inner_next = inner + ADDR_W'(1);
      idx_next   = stride_sum[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      scan_q <= scan;
      idx    <= '0;
      inner  <= '0;
      outer  <= '0;
      count  <= '0;
    end else if (step) begin
      idx    <= idx_next;
      inner  <= inner_next;
      outer  <= outer_next;
      count  <= count + ADDR_W'(1);
    end
  end

  assign addr = idx;
  assign last = (CW'(count) == (scan_q.length - CW'(1)));

endmodule
`default_nettype wire

### rtl/row_column_block_interleaver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// row_column_block_interleaver
// Collects a byte stream into a row by column matrix and emits each full
// block transposed (interleave) or with the inverse permutation.
// ----------------------------------------------------------------------------
// Each accepted byte is written into the cell store and produces no item
// until the matrix is full or the byte carries the end marker. The block is
// then read back one byte per cycle, while the output does not stall,
// through the store's registered read port; the input stalls during the
// readout and until the last read has drained. A partial block at the end
// of the stream comes out in arrival order. When rows times columns is zero
// or larger than the store, each byte is passed straight through as one item
// with config_error set, at one byte per cycle while the output does not
// stall. Any write to a defined register drops a partial block, and no byte
// is accepted in the cycle of a register write. There is no clearing pass
// after reset.
// ----------------------------------------------------------------------------
module row_column_block_interleaver #(
  parameter int MAX_CELLS = rci_pkg::MAX_CELLS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Configuration write channel.
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [rci_pkg::CFG_W-1:0] cfg_data,
  // Input channel.
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [7:0]               data_byte,
  input  wire logic                     stream_last,
  // Output channel.
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic      [7:0]               out_byte,
  output logic                          run_last,
  output logic                          stream_end,
  output logic                          config_error
);

  localparam int ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CNT_W  = ADDR_W + 1;
  localparam int CW     = rci_pkg::CFG_W;
  localparam int PROD_W = 2 * CW;

  rci_pkg::rci_state_t state, state_next;

  logic [CW-1:0]     column_count;
  logic [CW-1:0]     row_count;
  logic              direction;
  logic [ADDR_W-1:0] fill;
  logic              pend;
  logic              pend_last;
  logic              end_flag;

  logic [PROD_W-1:0] total;
  logic              cfg_bad;
  logic              cfg_take;
  logic              in_take;
  logic              out_free;
  logic [CNT_W-1:0]  fill_inc;
  logic              block_done;
  logic              gen_start;
  logic              issue;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_last;
  logic [7:0]        rd_data;
  rci_pkg::rci_scan_t scan;

  assign total    = PROD_W'(column_count) * PROD_W'(row_count);
  assign cfg_bad  = (total == '0) || (total > PROD_W'(MAX_CELLS));
  assign cfg_take = cfg_valid && cfg_ready;
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign fill_inc = CNT_W'(fill) + CNT_W'(1);
  assign block_done = (PROD_W'(fill_inc) >= total);

  always_comb begin
    scan.in_order  = !block_done;
    scan.stride    = direction ? row_count : column_count;
    scan.inner_len = direction ? column_count : row_count;
    scan.length    = block_done ? total[CW-1:0] : CW'(fill_inc);
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cfg_ready  = 1'b0;
    gen_start  = 1'b0;
    issue      = 1'b0;
    unique case (state)
      rci_pkg::ST_IDLE: begin
        // The output register must be free: a passthrough item goes there now.
        // A pending register write keeps the input waiting for that cycle.
        in_stall  = pend || !out_free || cfg_valid;
        cfg_ready = !pend;
        if (in_take && !cfg_bad && (block_done || stream_last)) begin
          gen_start  = 1'b1;
          state_next = rci_pkg::ST_SCAN;
        end
      end
      rci_pkg::ST_SCAN: begin
        // A new read may replace the read data only once it is consumed.
        issue = !pend || out_free;
        if (issue && rd_last) begin
          state_next = rci_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rci_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rci_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers and the fill counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= rci_pkg::COLUMN_COUNT_RESET;
      row_count    <= rci_pkg::ROW_COUNT_RESET;
      direction    <= 1'b0;
      fill         <= '0;
    end else if (cfg_take) begin
      unique case (cfg_index)
        rci_pkg::REG_COLUMN_COUNT: begin
          column_count <= cfg_data;
          fill         <= '0;
        end
        rci_pkg::REG_ROW_COUNT: begin
          row_count <= cfg_data;
          fill      <= '0;
        end
        rci_pkg::REG_DIRECTION: begin
          direction <= cfg_data[0];
          fill      <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_take && !cfg_bad) begin
      if (block_done || stream_last) begin
        fill <= '0;
      end else begin
        fill <= fill_inc[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gen_start) begin
      end_flag <= stream_last;
    end
    if (issue) begin
      pend_last <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (issue) begin
      pend <= 1'b1;
    end else if (out_free) begin
      pend <= 1'b0;
    end
  end

  // Output register, fed by the store readout or by a passthrough item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend && out_free) begin
      out_valid <= 1'b1;
    end else if (in_take && cfg_bad) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend && out_free) begin
      out_byte     <= rd_data;
      run_last     <= pend_last;
      stream_end   <= pend_last && end_flag;
      config_error <= 1'b0;
    end else if (in_take && cfg_bad) begin
      out_byte     <= data_byte;
      run_last     <= 1'b1;
      stream_end   <= stream_last;
      config_error <= 1'b1;
    end
  end

  rci_cell_ram #(
    .MAX_CELLS (MAX_CELLS),
    .ADDR_W    (ADDR_W)
  ) u_cell_ram (
    .clk   (clk),
    .we    (in_take && !cfg_bad),
    .waddr (fill),
    .wdata (data_byte),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rci_addr_gen #(
    .MAX_CELLS (MAX_CELLS),
    .ADDR_W    (ADDR_W)
  ) u_addr_gen (
    .clk   (clk),
    .start (gen_start),
    .step  (issue),
    .scan  (scan),
    .addr  (rd_addr),
    .last  (rd_last)
  );

endmodule
`default_nettype wire
